// ===== hw/rtl/cpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Charger power setpoint control package
// Shared types and fixed codes for the charger power setpoint controller.
// ----------------------------------------------------------------------------
package cpsc_pkg;

   // Command codes carried on the result channel.
   typedef enum logic [1:0] {
      ACT_SET_CURRENT = 2'd0,
      ACT_SET_VOLTAGE = 2'd1,
      ACT_ENABLE      = 2'd2,
      ACT_DISABLE     = 2'd3
   } action_type;

   // Configuration register indexes.
   localparam logic [2:0] REG_OPERATING_MODE     = 3'd0;
   localparam logic [2:0] REG_VOLTAGE_SETPOINT   = 3'd1;
   localparam logic [2:0] REG_REENABLE_VOLTAGE   = 3'd2;
   localparam logic [2:0] REG_LOWER_POWER_LIMIT  = 3'd3;
   localparam logic [2:0] REG_UPPER_POWER_LIMIT  = 3'd4;
   localparam logic [2:0] REG_TARGET_CONSUMPTION = 3'd5;
   localparam logic [2:0] REG_SOC_STOP_THRESHOLD = 3'd6;
   localparam logic [2:0] REG_FEATURE_ENABLES    = 3'd7;

   // Operating modes.
   localparam logic [1:0] MODE_OFF      = 2'd0;
   localparam logic [1:0] MODE_ON       = 2'd1;
   localparam logic [1:0] MODE_EXT_AUTO = 2'd2;
   localparam logic [1:0] MODE_INT_AUTO = 2'd3;

   // Tracked supply output state.
   localparam logic [1:0] OUT_UNKNOWN  = 2'd0;
   localparam logic [1:0] OUT_ENABLED  = 2'd1;
   localparam logic [1:0] OUT_DISABLED = 2'd2;

   // Fixed thresholds and periods.
   localparam logic [31:0] VOLT_REFRESH_MS = 32'd60000;
   localparam logic [31:0] RETRY_MS        = 32'd1000;
   localparam logic [13:0] ON_CURRENT      = 14'd75;
   localparam logic [13:0] OFF_CURRENT     = 14'd100;
   localparam logic [9:0]  EFF_MIN         = 10'd500;
   localparam logic [9:0]  EFF_ONE         = 10'd1000;
   localparam int          QUEUE_DEPTH     = 4;
   localparam int          DIV_BITS        = 28;

   // Sequencer states.
   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_OFF    = 11'b00000000010,
      S_VOLT   = 11'b00000000100,
      S_BRANCH = 11'b00000001000,
      S_MUL    = 11'b00000010000,
      S_SUM    = 11'b00000100000,
      S_DIV    = 11'b00001000000,
      S_LIM    = 11'b00010000000,
      S_SETCUR = 11'b00100000000,
      S_CUR    = 11'b01000000000,
      S_OUT    = 11'b10000000000
   } state_type;

endpackage

// ===== hw/rtl/charger_power_setpoint_control.sv =====
// ----------------------------------------------------------------------------
// Charger power setpoint control
// Per control tick, issues enable/disable, voltage and current commands.
// ----------------------------------------------------------------------------
// One request transaction is one control tick. The block is busy from the
// accepting edge until the last command of the tick has been taken. A tick
// passes the timer, voltage and branch states and may then go straight to
// the drain state. A zero current setpoint goes on through the set-current
// states. A computed current comes from the branch on an emergency start,
// or through the multiply and sum states in the power loop, and then runs
// through the divider, skipped at zero output voltage, and the limit state.
// The 28-step restoring divider forms current from power (or the emergency
// limit) and the output voltage one quotient bit per cycle. A response
// stall holds the block in the drain state. Commands queue internally (at
// most four) and are presented in order; rsp_last marks the final command.
// A tick that produces no command completes without any response.
module charger_power_setpoint_control #(
   parameter int SHUTDOWN_DELAY_MS = 60000,
   parameter int SETTLE_MS         = 4000,
   parameter int REARM_COUNT       = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [14:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_now_ms,
   input  logic [3:0]         req_reading_valid,
   input  logic [13:0]        req_out_current,
   input  logic [13:0]        req_out_voltage,
   input  logic [13:0]        req_out_power,
   input  logic [9:0]         req_efficiency,
   input  logic signed [15:0] req_meter_power,
   input  logic               req_meter_fresh,
   input  logic [6:0]         req_battery_level,
   input  logic [15:0]        req_bms_current_limit,
   input  logic signed [15:0] req_battery_current,
   input  logic [1:0]         req_event_flags,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_action,
   output logic [15:0]        rsp_value,
   output logic               rsp_auto_active,
   output logic               rsp_last
);

   // Configuration registers.
   logic [1:0]         mode_ff;
   logic [13:0]        vset_ff, reen_ff, lower_ff, upper_ff;
   logic signed [14:0] target_ff;
   logic [6:0]         socthr_ff;
   logic [1:0]         feat_ff;

   // Controller state.
   cpsc_pkg::state_type state_ff, state_in;
   logic [31:0] con_ff, con_in, nvr_ff, nvr_in, blk_ff, blk_in;
   logic        emerg_ff, emerg_in, auto_ff, auto_in;
   logic [3:0]  rc_ff, rc_in;
   logic [1:0]  ostate_ff, ostate_in;

   // Latched tick inputs.
   logic [31:0]        now_ff;
   logic [3:0]         valid_ff;
   logic [13:0]        cur_ff, volt_ff, pwr_ff;
   logic [9:0]         eff_ff;
   logic signed [15:0] meter_ff, bcur_ff;
   logic               fresh_ff;
   logic [6:0]         soc_ff;
   logic [15:0]        bms_ff;
   logic [1:0]         evt_ff;

   // Arithmetic work registers.
   logic signed [27:0] prod_ff, prod_in;
   logic [23:0]        pw_ff, pw_in;
   logic [27:0]        dvd_ff, dvd_in;
   logic [14:0]        rem_ff, rem_in;
   logic [4:0]         dcnt_ff, dcnt_in;
   logic               useperm_ff, useperm_in;
   logic [15:0]        cval_ff, cval_in;

   // Command queue.
   logic [1:0]  q_act_ff [cpsc_pkg::QUEUE_DEPTH];
   logic [15:0] q_val_ff [cpsc_pkg::QUEUE_DEPTH];
   logic [2:0]  cnt_ff, cnt_in;
   logic [1:0]  idx_ff, idx_in;
   logic        push_en;
   logic [1:0]  push_act;
   logic [15:0] push_val;

   logic req_accept, rsp_accept;
   logic cv, vv, pv, auto_mode;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = (state_ff != cpsc_pkg::S_IDLE);
   assign cv = valid_ff[0];
   assign vv = valid_ff[1];
   assign pv = valid_ff[2];
   assign auto_mode = (mode_ff == cpsc_pkg::MODE_EXT_AUTO) ||
                      (mode_ff == cpsc_pkg::MODE_INT_AUTO);

   // Result channel is driven straight from the queue.
   assign rsp_valid       = (state_ff == cpsc_pkg::S_OUT) && ({1'b0, idx_ff} < cnt_ff);
   assign rsp_action      = q_act_ff[idx_ff];
   assign rsp_value       = q_val_ff[idx_ff];
   assign rsp_auto_active = auto_ff;
   assign rsp_last        = ({1'b0, idx_ff} == (cnt_ff - 3'd1));

   // Sequencer and shared arithmetic.
   always_comb begin
      logic [31:0]        con_t;
      logic [3:0]         rc_t;
      logic signed [17:0] diff;
      logic signed [28:0] tmw;
      logic signed [28:0] lim_lo, lim_hi;
      logic [14:0]        trial;
      logic               ge;
      logic signed [18:0] perm;
      logic signed [29:0] cq;
      state_in   = state_ff;
      con_in     = con_ff;
      nvr_in     = nvr_ff;
      blk_in     = blk_ff;
      emerg_in   = emerg_ff;
      auto_in    = auto_ff;
      rc_in      = rc_ff;
      ostate_in  = ostate_ff;
      prod_in    = prod_ff;
      pw_in      = pw_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      dcnt_in    = dcnt_ff;
      useperm_in = useperm_ff;
      cval_in    = cval_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      push_en    = 1'b0;
      push_act   = cpsc_pkg::ACT_SET_CURRENT;
      push_val   = '0;
      con_t      = '0;
      rc_t       = rc_ff;
      diff       = '0;
      tmw        = '0;
      lim_lo     = '0;
      lim_hi     = '0;
      trial      = '0;
      ge         = 1'b0;
      perm       = '0;
      cq         = '0;
      unique case (state_ff)
         cpsc_pkg::S_IDLE: begin
            if (req_accept) begin
               cnt_in   = '0;
               idx_in   = '0;
               state_in = cpsc_pkg::S_OFF;
            end
         end
         // Current-flow timer and quiet shutdown.
         cpsc_pkg::S_OFF: begin
            con_t = (cv && (cur_ff > cpsc_pkg::ON_CURRENT)) ? now_ff : con_ff;
            con_in = con_t;
            if (((con_t + 32'(SHUTDOWN_DELAY_MS)) < now_ff) && auto_mode &&
                (ostate_ff != cpsc_pkg::OUT_DISABLED)) begin
               push_en   = 1'b1;
               push_act  = cpsc_pkg::ACT_DISABLE;
               ostate_in = cpsc_pkg::OUT_DISABLED;
            end
            state_in = cpsc_pkg::S_VOLT;
         end
         // Periodic voltage setpoint.
         cpsc_pkg::S_VOLT: begin
            if (((mode_ff == cpsc_pkg::MODE_INT_AUTO) || emerg_ff) && (nvr_ff < now_ff)) begin
               push_en  = 1'b1;
               push_act = cpsc_pkg::ACT_SET_VOLTAGE;
               push_val = {2'b00, vset_ff};
               nvr_in   = now_ff + cpsc_pkg::VOLT_REFRESH_MS;
            end
            state_in = cpsc_pkg::S_BRANCH;
         end
         // Emergency charge and gating of the power loop.
         cpsc_pkg::S_BRANCH: begin
            state_in = cpsc_pkg::S_OUT;
            if (!emerg_ff && feat_ff[0] && evt_ff[0]) begin
               if (vv) begin
                  emerg_in   = 1'b1;
                  useperm_in = 1'b0;
                  if (volt_ff == '0) begin
                     dvd_in   = 28'd65535;
                     state_in = cpsc_pkg::S_LIM;
                  end else begin
                     dvd_in   = 28'(upper_ff * 28'd10000);
                     rem_in   = '0;
                     dcnt_in  = 5'(cpsc_pkg::DIV_BITS - 1);
                     state_in = cpsc_pkg::S_DIV;
                  end
               end
            end else if (emerg_ff && !evt_ff[0]) begin
               cval_in = '0;
               if (cv && (cur_ff < cpsc_pkg::OFF_CURRENT)) emerg_in = 1'b0;
               state_in = cpsc_pkg::S_SETCUR;
            end else if ((mode_ff == cpsc_pkg::MODE_INT_AUTO) && !(blk_ff > now_ff)) begin
               if (!vv || !pv || !cv) begin
                  blk_in = now_ff + cpsc_pkg::RETRY_MS;
               end else begin
                  if (volt_ff < reen_ff) rc_t = 4'(REARM_COUNT);
                  rc_in = rc_t;
                  if (evt_ff[1]) begin
                     cval_in  = '0;
                     blk_in   = now_ff + cpsc_pkg::RETRY_MS;
                     state_in = cpsc_pkg::S_SETCUR;
                  end else if (fresh_ff && (rc_t != '0)) begin
                     state_in = cpsc_pkg::S_MUL;
                  end
               end
            end
         end
         // Power error times efficiency; output power in mW.
         cpsc_pkg::S_MUL: begin
            diff     = 18'(target_ff) - 18'(meter_ff);
            prod_in  = 28'(diff) * $signed({18'b0, eff_ff});
            pw_in    = 24'(pwr_ff * 24'd1000);
            state_in = cpsc_pkg::S_SUM;
         end
         // Power target decisions and divider launch.
         cpsc_pkg::S_SUM: begin
            tmw = $signed({5'b0, pw_ff}) + 29'(prod_ff);
            if (feat_ff[1] && (soc_ff >= socthr_ff)) tmw = '0;
            lim_lo = $signed({5'b0, 24'(lower_ff * 24'd1000)});
            lim_hi = $signed({5'b0, 24'(upper_ff * 24'd1000)});
            if (tmw > lim_lo) begin
               if (pwr_ff < lower_ff) begin
                  rc_t = rc_ff - 4'd1;
               end else begin
                  rc_t = 4'(REARM_COUNT);
               end
               rc_in = rc_t;
               if (rc_t == '0) begin
                  auto_in  = 1'b0;
                  cval_in  = '0;
                  state_in = cpsc_pkg::S_SETCUR;
               end else begin
                  if (tmw > lim_hi) tmw = lim_hi;
                  auto_in    = 1'b1;
                  blk_in     = now_ff + 32'(SETTLE_MS);
                  useperm_in = 1'b1;
                  if (volt_ff == '0) begin
                     dvd_in   = 28'd65535;
                     state_in = cpsc_pkg::S_LIM;
                  end else begin
                     dvd_in   = 28'(tmw[24:0] * 28'd10);
                     rem_in   = '0;
                     dcnt_in  = 5'(cpsc_pkg::DIV_BITS - 1);
                     state_in = cpsc_pkg::S_DIV;
                  end
               end
            end else begin
               auto_in  = 1'b0;
               cval_in  = '0;
               state_in = cpsc_pkg::S_SETCUR;
            end
         end
         // One quotient bit per cycle.
         cpsc_pkg::S_DIV: begin
            trial  = {rem_ff[13:0], dvd_ff[cpsc_pkg::DIV_BITS-1]};
            ge     = (trial >= {1'b0, volt_ff});
            rem_in = ge ? (trial - {1'b0, volt_ff}) : trial;
            dvd_in = {dvd_ff[cpsc_pkg::DIV_BITS-2:0], ge};
            dcnt_in = dcnt_ff - 5'd1;
            if (dcnt_ff == '0) state_in = cpsc_pkg::S_LIM;
         end
         // Battery limit and saturation.
         cpsc_pkg::S_LIM: begin
            perm = $signed({3'b0, bms_ff}) - 19'(bcur_ff) + $signed({5'b0, cur_ff});
            cq   = $signed({2'b0, dvd_ff});
            if (useperm_ff && (30'(perm) < cq)) cq = 30'(perm);
            if (cq < 0) begin
               cval_in = '0;
            end else if (cq > 30'sd65535) begin
               cval_in = 16'hFFFF;
            end else begin
               cval_in = cq[15:0];
            end
            state_in = cpsc_pkg::S_SETCUR;
         end
         // Enable output ahead of a significant current.
         cpsc_pkg::S_SETCUR: begin
            if ((cval_ff > 16'(cpsc_pkg::ON_CURRENT)) && auto_mode) begin
               con_in = now_ff;
               if (ostate_ff != cpsc_pkg::OUT_ENABLED) begin
                  push_en   = 1'b1;
                  push_act  = cpsc_pkg::ACT_ENABLE;
                  ostate_in = cpsc_pkg::OUT_ENABLED;
               end
            end
            state_in = cpsc_pkg::S_CUR;
         end
         cpsc_pkg::S_CUR: begin
            push_en  = 1'b1;
            push_act = cpsc_pkg::ACT_SET_CURRENT;
            push_val = cval_ff;
            state_in = cpsc_pkg::S_OUT;
         end
         // Drain queued commands.
         cpsc_pkg::S_OUT: begin
            if (cnt_ff == '0) begin
               state_in = cpsc_pkg::S_IDLE;
            end else if (rsp_accept) begin
               idx_in = idx_ff + 2'd1;
               if (rsp_last) state_in = cpsc_pkg::S_IDLE;
            end
         end
         default: state_in = cpsc_pkg::S_IDLE;
      endcase
      if (push_en && (cnt_ff < 3'(cpsc_pkg::QUEUE_DEPTH))) cnt_in = cnt_ff + 3'd1;
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cpsc_pkg::S_IDLE;
         con_ff    <= '0;
         nvr_ff    <= '0;
         blk_ff    <= '0;
         emerg_ff  <= 1'b0;
         auto_ff   <= 1'b0;
         rc_ff     <= 4'(REARM_COUNT);
         ostate_ff <= cpsc_pkg::OUT_UNKNOWN;
         cnt_ff    <= '0;
         idx_ff    <= '0;
         mode_ff   <= cpsc_pkg::MODE_EXT_AUTO;
         vset_ff   <= 14'd5360;
         reen_ff   <= 14'd4200;
         lower_ff  <= 14'd150;
         upper_ff  <= 14'd2000;
         target_ff <= '0;
         socthr_ff <= 7'd95;
         feat_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         con_ff    <= con_in;
         nvr_ff    <= nvr_in;
         blk_ff    <= blk_in;
         emerg_ff  <= emerg_in;
         auto_ff   <= auto_in;
         rc_ff     <= rc_in;
         ostate_ff <= ostate_in;
         cnt_ff    <= cnt_in;
         idx_ff    <= idx_in;
         if (csr_we) begin
            unique case (csr_index)
               cpsc_pkg::REG_OPERATING_MODE:     mode_ff   <= csr_wdata[1:0];
               cpsc_pkg::REG_VOLTAGE_SETPOINT:   vset_ff   <= csr_wdata[13:0];
               cpsc_pkg::REG_REENABLE_VOLTAGE:   reen_ff   <= csr_wdata[13:0];
               cpsc_pkg::REG_LOWER_POWER_LIMIT:  lower_ff  <= csr_wdata[13:0];
               cpsc_pkg::REG_UPPER_POWER_LIMIT:  upper_ff  <= csr_wdata[13:0];
               cpsc_pkg::REG_TARGET_CONSUMPTION: target_ff <= $signed(csr_wdata);
               cpsc_pkg::REG_SOC_STOP_THRESHOLD: socthr_ff <= csr_wdata[6:0];
               cpsc_pkg::REG_FEATURE_ENABLES:    feat_ff   <= csr_wdata[1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload and work registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         now_ff   <= req_now_ms;
         valid_ff <= req_reading_valid;
         cur_ff   <= req_out_current;
         volt_ff  <= req_out_voltage;
         pwr_ff   <= req_out_power;
         eff_ff   <= (req_reading_valid[3] && (req_efficiency > cpsc_pkg::EFF_MIN)) ?
                     req_efficiency : cpsc_pkg::EFF_ONE;
         meter_ff <= req_meter_power;
         fresh_ff <= req_meter_fresh;
         soc_ff   <= req_battery_level;
         bms_ff   <= req_bms_current_limit;
         bcur_ff  <= req_battery_current;
         evt_ff   <= req_event_flags;
      end
      prod_ff    <= prod_in;
      pw_ff      <= pw_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      dcnt_ff    <= dcnt_in;
      useperm_ff <= useperm_in;
      cval_ff    <= cval_in;
      if (push_en && (cnt_ff < 3'(cpsc_pkg::QUEUE_DEPTH))) begin
         q_act_ff[cnt_ff[1:0]] <= push_act;
         q_val_ff[cnt_ff[1:0]] <= push_val;
      end
   end

   // A response is only offered while new ticks are held off.
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("response offered while accepting ticks");

   // The command queue never overflows.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(cpsc_pkg::QUEUE_DEPTH)) else $error("command queue overflow");

   // A new tick starts with an empty queue.
   a_tick_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (cnt_ff == '0) && (idx_ff == '0)) else $error("queue not cleared");

   // The divider finishes into the limit stage.
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cpsc_pkg::S_DIV) && (dcnt_ff == '0) |=> (state_ff == cpsc_pkg::S_LIM))
      else $error("divider exit");

endmodule
